// ----- rtl/core/mffc_pkg.sv -----
// shared types and constants of the median filtered follow controller
`default_nettype none

package mffc_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int LEVEL_W         = 12;
    localparam int DUTY_W          = 14;
    localparam int COUNT_W         = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 14;
    localparam int OUT_TDATA_W     = 32;

    localparam logic [LEVEL_W-1:0] NEAR_RST   = 12'd3000;
    localparam logic [LEVEL_W-1:0] FAR_RST    = 12'd500;
    localparam logic [LEVEL_W-1:0] TARGET_RST = 12'd1500;
    localparam logic [DUTY_W-1:0]  RUN_RST    = 14'd5000;
    localparam logic [DUTY_W-1:0]  HALT_RST   = 14'd0;
    localparam logic [COUNT_W-1:0] SETTLE_RST = 8'd10;

    typedef enum logic [1:0] {
        PH_SETTLE = 2'd0,
        PH_WAIT   = 2'd1,
        PH_FOLLOW = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR   = 3'd0,
        CFG_FAR    = 3'd1,
        CFG_TARGET = 3'd2,
        CFG_RUN    = 3'd3,
        CFG_HALT   = 3'd4,
        CFG_SETTLE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] near_limit;
        logic [LEVEL_W-1:0] far_limit;
        logic [LEVEL_W-1:0] target_level;
        logic [DUTY_W-1:0]  run_duty;
        logic [DUTY_W-1:0]  halt_duty;
        logic [COUNT_W-1:0] settle_samples;
    } t_cfg;

    typedef struct packed {
        logic               reverse;
        logic [DUTY_W-1:0]  duty;
        t_phase             phase;
    } t_ctrl_res;

endpackage

`default_nettype wire

// ----- rtl/core/median_filtered_follow_controller_unit.sv -----
// top level of the median filtered follow controller
//
// usage
//   s channel: one raw distance sample per beat in i_s_tdata, larger is nearer
//   m channel: one result beat per sample: filtered level, direction, duty, phase
//   cfg channel: register writes by index, always ready; write only while idle
//   latency: a sample accepted at edge n is registered, and its result is shown
//   on the m channel from edge n+1 on (one input register, one result register)
//   throughput: one sample per cycle, set by the single compute step between the
//   input register and the result register
//   stall: while the receiver holds i_m_tready low the result holds, the input
//   register fills and o_s_tready then drops until the result is taken
//   reset: clears both pipeline registers, the median delay line to zero, the
//   phase to settle with a zero count, and the registers to their defaults
`default_nettype none

module median_filtered_follow_controller_unit #(
    parameter int SAMPLE_BITS = mffc_pkg::SAMPLE_BITS_DEF,
    parameter int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // sample stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]               i_s_tdata,  // sample
    // result stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // filtered[11:0], reverse[12], duty[26:13], phase[28:27]
    output logic [mffc_pkg::OUT_TDATA_W-1:0]         o_m_tdata,
    // register writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [mffc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mffc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CMP_W = (SAMPLE_BITS > mffc_pkg::LEVEL_W) ? SAMPLE_BITS
                                                              : mffc_pkg::LEVEL_W;

    mffc_pkg::t_cfg                   r_cfg;
    logic                             r_in_valid;
    logic [SAMPLE_BITS-1:0]           r_in_sample;
    logic                             r_out_valid;
    logic [mffc_pkg::LEVEL_W-1:0]     r_out_filtered;
    mffc_pkg::t_ctrl_res              r_out_res;
    logic                             advance;
    logic                             s_beat;
    logic [SAMPLE_BITS-1:0]           level;
    logic [CMP_W-1:0]                 level_x;
    mffc_pkg::t_ctrl_res              res;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign s_beat      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit     <= mffc_pkg::NEAR_RST;
            r_cfg.far_limit      <= mffc_pkg::FAR_RST;
            r_cfg.target_level   <= mffc_pkg::TARGET_RST;
            r_cfg.run_duty       <= mffc_pkg::RUN_RST;
            r_cfg.halt_duty      <= mffc_pkg::HALT_RST;
            r_cfg.settle_samples <= mffc_pkg::SETTLE_RST;
        end else if (i_cfg_valid) begin
            case (mffc_pkg::t_cfg_idx'(i_cfg_index))
                mffc_pkg::CFG_NEAR:   r_cfg.near_limit     <= i_cfg_data[mffc_pkg::LEVEL_W-1:0];
                mffc_pkg::CFG_FAR:    r_cfg.far_limit      <= i_cfg_data[mffc_pkg::LEVEL_W-1:0];
                mffc_pkg::CFG_TARGET: r_cfg.target_level   <= i_cfg_data[mffc_pkg::LEVEL_W-1:0];
                mffc_pkg::CFG_RUN:    r_cfg.run_duty       <= i_cfg_data;
                mffc_pkg::CFG_HALT:   r_cfg.halt_duty      <= i_cfg_data;
                mffc_pkg::CFG_SETTLE: r_cfg.settle_samples <= i_cfg_data[mffc_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_beat) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_in_sample <= i_s_tdata[SAMPLE_BITS-1:0];
        end
        if (advance) begin
            r_out_filtered <= level_x[mffc_pkg::LEVEL_W-1:0];
            r_out_res      <= res;
        end
    end

    mffc_median #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_in_sample),
        .o_median (level)
    );

    assign level_x = CMP_W'(level);

    mffc_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_level (level),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_res.phase, r_out_res.duty, r_out_res.reverse,
                         r_out_filtered};

`ifndef SYNTHESIS
    a_rev_only_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.reverse |-> r_out_res.phase == mffc_pkg::PH_FOLLOW)
        else $error("backward drive outside follow phase");

    a_halt_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.phase != mffc_pkg::PH_FOLLOW
        |-> r_out_res.duty == r_cfg.halt_duty && !r_out_res.reverse)
        else $error("wheels driven outside follow phase");

    a_beat_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |=> r_in_valid)
        else $error("accepted sample not held in input register");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mffc_median.sv -----
// three tap delay line with median of three selection
`default_nettype none

module mffc_median #(
    parameter int SAMPLE_BITS = mffc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [SAMPLE_BITS-1:0] o_median
);

    logic [SAMPLE_BITS-1:0] r_prev;
    logic [SAMPLE_BITS-1:0] r_older;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_older <= '0;
        end else if (i_step) begin
            r_older <= r_prev;
            r_prev  <= i_sample;
        end
    end

    always_comb begin
        lo = (i_sample < r_prev) ? i_sample : r_prev;
        hi = (i_sample < r_prev) ? r_prev : i_sample;
        if (r_older <= lo) begin
            o_median = lo;
        end else if (r_older >= hi) begin
            o_median = hi;
        end else begin
            o_median = r_older;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mffc_ctrl.sv -----
// settle, wait and follow phase sequencer with wheel command
`default_nettype none

module mffc_ctrl #(
    parameter int SAMPLE_BITS = mffc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [SAMPLE_BITS-1:0] i_level,
    input  wire mffc_pkg::t_cfg         i_cfg,
    output mffc_pkg::t_ctrl_res         o_res
);

    localparam int CMP_W = (SAMPLE_BITS > mffc_pkg::LEVEL_W) ? SAMPLE_BITS
                                                              : mffc_pkg::LEVEL_W;

    mffc_pkg::t_phase              r_phase;
    mffc_pkg::t_phase              n_phase;
    logic [mffc_pkg::COUNT_W-1:0]  r_count;
    logic [mffc_pkg::COUNT_W-1:0]  n_count;
    logic [mffc_pkg::COUNT_W-1:0]  count_inc;
    logic [mffc_pkg::COUNT_W-1:0]  need;
    logic [CMP_W-1:0]              v;
    logic [CMP_W-1:0]              near_x;
    logic [CMP_W-1:0]              far_x;
    logic [CMP_W-1:0]              target_x;
    logic                          strict_in;
    logic                          in_range;

    assign v        = CMP_W'(i_level);
    assign near_x   = CMP_W'(i_cfg.near_limit);
    assign far_x    = CMP_W'(i_cfg.far_limit);
    assign target_x = CMP_W'(i_cfg.target_level);
    assign strict_in = (v > far_x) && (v < near_x);
    assign in_range = (v >= far_x) && (v <= near_x);
    assign need     = (i_cfg.settle_samples == '0) ? mffc_pkg::COUNT_W'(1)
                                                   : i_cfg.settle_samples;
    assign count_inc = r_count + mffc_pkg::COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mffc_pkg::PH_SETTLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        case (r_phase)
            mffc_pkg::PH_WAIT: begin
                if (in_range) begin
                    if (strict_in) begin
                        n_phase = mffc_pkg::PH_FOLLOW;
                    end else begin
                        n_phase = mffc_pkg::PH_SETTLE;
                        n_count = '0;
                    end
                end
            end
            mffc_pkg::PH_FOLLOW: begin
                if (!strict_in) begin
                    n_phase = mffc_pkg::PH_SETTLE;
                    n_count = '0;
                end
            end
            default: begin
                if (count_inc >= need) begin
                    n_phase = mffc_pkg::PH_WAIT;
                    n_count = '0;
                end else begin
                    n_phase = mffc_pkg::PH_SETTLE;
                    n_count = count_inc;
                end
            end
        endcase
    end

    // wheel command
    always_comb begin
        o_res.reverse = 1'b0;
        o_res.duty    = i_cfg.halt_duty;
        o_res.phase   = n_phase;
        case (r_phase)
            mffc_pkg::PH_FOLLOW: begin
                if (strict_in) begin
                    if (v > target_x) begin
                        o_res.reverse = 1'b1;
                        o_res.duty    = i_cfg.run_duty;
                    end else if (v < target_x) begin
                        o_res.duty    = i_cfg.run_duty;
                    end
                end
            end
            default: begin
                o_res.reverse = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
